/* rtl/psma_pkg.sv */
`timescale 1ns / 1ps
package psma_pkg;

	localparam int DEF_NUM_SENSORS = 1024;
	localparam int DEF_WINDOW      = 5;

	localparam int DIV_K     = 19;
	localparam int CNT_ARG_W = 4;

	typedef struct packed {
		logic               bad;
		logic [15:0]        id;
		logic signed [15:0] temp;
	} cmd_t;

	typedef struct packed {
		logic [15:0]        node_id;
		logic signed [15:0] average;
		logic [1:0]         level;
		logic               changed;
		logic               bad_id;
	} res_t;

	typedef struct packed {
		logic signed [15:0] hot;
		logic signed [15:0] cold;
	} thr_t;

	function automatic logic [DIV_K-1:0] recip(input logic [CNT_ARG_W-1:0] c);
		logic [DIV_K-1:0] r;
		case (c)
			4'd1: r = {DIV_K{1'b1}};
			4'd2: r = DIV_K'((1 << DIV_K) / 2);
			4'd3: r = DIV_K'((1 << DIV_K) / 3);
			4'd4: r = DIV_K'((1 << DIV_K) / 4);
			4'd5: r = DIV_K'((1 << DIV_K) / 5);
			4'd6: r = DIV_K'((1 << DIV_K) / 6);
			4'd7: r = DIV_K'((1 << DIV_K) / 7);
			4'd8: r = DIV_K'((1 << DIV_K) / 8);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/psma_ram.sv */
`timescale 1ns / 1ps
module psma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/psma_fifo.sv */
`timescale 1ns / 1ps
module psma_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/psma_front.sv */
`timescale 1ns / 1ps
module psma_front import psma_pkg::*; #(
	parameter int NUM_SENSORS = DEF_NUM_SENSORS
) (
	input  logic               push,
	output logic               full,
	input  logic [15:0]        src_id,
	input  logic signed [15:0] temperature,
	input  logic [10:0]        id_limit,
	input  logic               cmd_full,
	input  logic               clearing,
	output logic               cmd_push,
	output cmd_t               cmd
);

	logic bad;

	assign full     = cmd_full || clearing;
	assign cmd_push = push && !full;
	assign bad      = ({1'b0, src_id} >= 17'(NUM_SENSORS)) ||
	                  (src_id >= {5'd0, id_limit});

	always_comb begin
		cmd.bad  = bad;
		cmd.id   = src_id;
		cmd.temp = temperature;
	end

endmodule

/* rtl/psma_back.sv */
`timescale 1ns / 1ps
module psma_back import psma_pkg::*; #(
	parameter int NUM_SENSORS = DEF_NUM_SENSORS,
	parameter int WINDOW      = DEF_WINDOW
) (
	input  logic clk,
	input  logic arst_n,
	input  thr_t thr,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_push,
	output res_t res,
	input  logic res_full,
	output logic clearing
);

	localparam int IDX_W     = NUM_SENSORS > 1 ? $clog2(NUM_SENSORS) : 1;
	localparam int SMP_DEPTH = NUM_SENSORS * WINDOW;
	localparam int ADDR_W    = SMP_DEPTH > 1 ? $clog2(SMP_DEPTH) : 1;
	localparam int PTR_W     = WINDOW > 1 ? $clog2(WINDOW) : 1;
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int META_W    = PTR_W + CNT_W + 2;
	localparam int SUM_W     = 17 + $clog2(WINDOW);
	localparam int ABS_W     = SUM_W - 1;
	localparam int PROD_W    = ABS_W + DIV_K;
	localparam int QC_W      = ABS_W + CNT_W;

	localparam logic [1:0] LVL_NORMAL = 2'd0;
	localparam logic [1:0] LVL_HOT    = 2'd1;
	localparam logic [1:0] LVL_COLD   = 2'd2;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_META  = 4'd2;
	localparam logic [3:0] ST_SUM   = 4'd3;
	localparam logic [3:0] ST_ABS   = 4'd4;
	localparam logic [3:0] ST_DIV1  = 4'd5;
	localparam logic [3:0] ST_DIV2  = 4'd6;
	localparam logic [3:0] ST_DIV3  = 4'd7;
	localparam logic [3:0] ST_CLASS = 4'd8;
	localparam logic [3:0] ST_BAD   = 4'd9;

	logic [3:0]         state_q;
	logic [3:0]         state_d;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               rd_pend_q;

	logic [15:0]        id_q;
	logic signed [15:0] temp_q;
	logic [ADDR_W-1:0]  base_q;
	logic [PTR_W-1:0]   ptr_next_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         last_lvl_q;
	logic signed [SUM_W-1:0] acc_q;
	logic               neg_q;
	logic [ABS_W-1:0]   mag_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ABS_W-1:0]   qe_q;
	logic [QC_W-1:0]    qc_q;
	logic signed [15:0] avg_q;

	logic               meta_we;
	logic [IDX_W-1:0]   meta_waddr;
	logic [META_W-1:0]  meta_wdata;
	logic               meta_re;
	logic [META_W-1:0]  meta_rd;
	logic [PTR_W-1:0]   meta_ptr;
	logic [CNT_W-1:0]   meta_cnt;
	logic [1:0]         meta_lvl;
	logic [PTR_W-1:0]   ptr_cur;
	logic [PTR_W-1:0]   ptr_nxt;
	logic [CNT_W-1:0]   cnt_nxt;

	logic               smp_we;
	logic               smp_re;
	logic [ADDR_W-1:0]  smp_waddr;
	logic [ADDR_W-1:0]  smp_raddr;
	logic [15:0]        smp_rd;

	logic [SUM_W-1:0]   acc_abs;
	logic [ABS_W-1:0]   qe;
	logic [QC_W-1:0]    rem;
	logic [ABS_W-1:0]   q_fin;
	logic signed [15:0] avg_nxt;
	logic [1:0]         lvl;

	assign clearing = (state_q == ST_CLEAR);
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign meta_re  = cmd_pop && !cmd.bad;

	assign meta_ptr = meta_rd[META_W-1 -: PTR_W];
	assign meta_cnt = meta_rd[2 +: CNT_W];
	assign meta_lvl = meta_rd[1:0];
	assign ptr_cur  = (int'(meta_ptr) >= WINDOW) ? '0 : meta_ptr;
	assign ptr_nxt  = (int'(ptr_cur) == WINDOW - 1) ? '0 : ptr_cur + 1'b1;
	assign cnt_nxt  = (int'(meta_cnt) < WINDOW) ? meta_cnt + 1'b1 : meta_cnt;

	assign smp_we    = (state_q == ST_META);
	assign smp_waddr = base_q + ADDR_W'(ptr_cur);
	assign smp_re    = (state_q == ST_SUM) && (rd_idx_q != cnt_q);
	assign smp_raddr = base_q + ADDR_W'(rd_idx_q);

	assign acc_abs = acc_q[SUM_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign qe      = prod_q[PROD_W-1 -: ABS_W];
	assign rem     = {{CNT_W{1'b0}}, mag_q} - qc_q;
	assign q_fin   = qe_q + ABS_W'(rem >= QC_W'(cnt_q));
	assign avg_nxt = neg_q ? (16'sd0 - signed'(q_fin[15:0])) : signed'(q_fin[15:0]);

	always_comb begin
		if (avg_q > thr.hot) begin
			lvl = LVL_HOT;
		end else if (avg_q < thr.cold) begin
			lvl = LVL_COLD;
		end else begin
			lvl = LVL_NORMAL;
		end
	end

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		case (state_q)
			ST_CLASS: begin
				res_push    = !res_full;
				res.node_id = id_q;
				res.average = avg_q;
				res.level   = lvl;
				res.changed = (lvl != last_lvl_q);
			end
			ST_BAD: begin
				res_push   = !res_full;
				res.bad_id = 1'b1;
			end
			default: ;
		endcase
	end

	assign meta_we    = clearing || ((state_q == ST_CLASS) && !res_full);
	assign meta_waddr = clearing ? clr_idx_q : id_q[IDX_W-1:0];
	assign meta_wdata = clearing ? '0 : {ptr_next_q, cnt_q, lvl};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == IDX_W'(NUM_SENSORS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!cmd_empty) begin
					state_d = cmd.bad ? ST_BAD : ST_META;
				end
			end
			ST_META: state_d = ST_SUM;
			ST_SUM: begin
				if (!smp_re && !rd_pend_q) begin
					state_d = ST_ABS;
				end
			end
			ST_ABS:  state_d = ST_DIV1;
			ST_DIV1: state_d = ST_DIV2;
			ST_DIV2: state_d = ST_DIV3;
			ST_DIV3: state_d = ST_CLASS;
			ST_CLASS, ST_BAD: begin
				if (!res_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= smp_re;
			if (clearing) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (state_q == ST_META) begin
				rd_idx_q <= '0;
			end else if (smp_re) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			id_q   <= cmd.id;
			temp_q <= cmd.temp;
			base_q <= ADDR_W'(cmd.id[IDX_W-1:0] * WINDOW);
		end
		if (state_q == ST_META) begin
			ptr_next_q <= ptr_nxt;
			cnt_q      <= cnt_nxt;
			last_lvl_q <= meta_lvl;
			acc_q      <= '0;
		end else if (rd_pend_q) begin
			acc_q <= acc_q + {{(SUM_W - 16){smp_rd[15]}}, smp_rd};
		end
		if (state_q == ST_ABS) begin
			neg_q <= acc_q[SUM_W-1];
			mag_q <= acc_abs[ABS_W-1:0];
		end
		if (state_q == ST_DIV1) begin
			prod_q <= mag_q * recip(CNT_ARG_W'(cnt_q));
		end
		if (state_q == ST_DIV2) begin
			qe_q <= qe;
			qc_q <= qe * cnt_q;
		end
		if (state_q == ST_DIV3) begin
			avg_q <= avg_nxt;
		end
	end

	psma_ram #(
		.WIDTH (META_W),
		.DEPTH (NUM_SENSORS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (cmd.id[IDX_W-1:0]),
		.rdata (meta_rd)
	);

	psma_ram #(
		.WIDTH (16),
		.DEPTH (SMP_DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (smp_waddr),
		.wdata (temp_q),
		.re    (smp_re),
		.raddr (smp_raddr),
		.rdata (smp_rd)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result transfer into a full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (cnt_q != '0 && int'(cnt_q) <= WINDOW))
		else $error("fill count out of range while summing");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!cmd_pop && !res_push && !smp_we))
		else $error("activity during clearing pass");

	a_push_return: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after result");

endmodule

/* rtl/per_sensor_moving_average_alarm_core.sv */
`timescale 1ns / 1ps
// Per-sensor moving average with hot/cold alarm.
// Input queue side: present src_id and temperature with push; the reading
// transfers on a clock edge with push high and full low.
// Result queue side: while empty is low the oldest result sits on node_id,
// average, level, changed and bad_id; it transfers on an edge with pop high.
// Configuration: APB write of hot threshold (0x0), cold threshold (0x4) and
// id limit (0x8); reads return the register values. pready is tied high.
// Processing: a valid reading goes through a sequential sample read loop, one
// sample per cycle from the sample memory, and a three-step reciprocal divide
// before its result shows on the result side; a rejected id goes straight to
// a bad_id result.
// One reading is processed at a time; the back end takes no new reading until
// the current one's result has been pushed.
// Reset: after arst_n releases, the per-sensor pointer/count/class memory is
// swept to zero entry by entry over all NUM_SENSORS entries; full stays high.
// Stall: the result queue holds two results, then the back end holds; the
// command queue holds two readings, then full rises.
module per_sensor_moving_average_alarm_core import psma_pkg::*; #(
	parameter int NUM_SENSORS = DEF_NUM_SENSORS,
	parameter int WINDOW      = DEF_WINDOW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [15:0]        src_id,
	input  logic signed [15:0] temperature,
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        node_id,
	output logic signed [15:0] average,
	output logic [1:0]         level,
	output logic               changed,
	output logic               bad_id
);

	localparam logic [1:0] REG_HOT      = 2'd0;
	localparam logic [1:0] REG_COLD     = 2'd1;
	localparam logic [1:0] REG_ID_LIMIT = 2'd2;

	localparam logic signed [15:0] HOT_RESET      = 16'sd7168;
	localparam logic signed [15:0] COLD_RESET     = 16'sd4608;
	localparam logic [10:0]        ID_LIMIT_RESET = 11'd1000;

	logic signed [15:0] hot_q;
	logic signed [15:0] cold_q;
	logic [10:0]        id_limit_q;
	logic               cfg_wr;

	logic               cmd_push;
	cmd_t               cmd_in;
	logic               cmd_full;
	logic               cmd_empty;
	logic               cmd_pop;
	logic [$bits(cmd_t)-1:0] cmd_rdata;
	cmd_t               cmd_out;

	logic               res_push;
	res_t               res_in;
	logic               res_full;
	logic [$bits(res_t)-1:0] res_rdata;
	res_t               res_out;

	logic               clearing;
	thr_t               thr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_q      <= HOT_RESET;
			cold_q     <= COLD_RESET;
			id_limit_q <= ID_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_HOT:      hot_q      <= pwdata[15:0];
				REG_COLD:     cold_q     <= pwdata[15:0];
				REG_ID_LIMIT: id_limit_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HOT:      prdata = {{16{hot_q[15]}}, hot_q};
			REG_COLD:     prdata = {{16{cold_q[15]}}, cold_q};
			REG_ID_LIMIT: prdata = {21'd0, id_limit_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_comb begin
		thr.hot  = hot_q;
		thr.cold = cold_q;
	end

	psma_front #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_front (
		.push        (push),
		.full        (full),
		.src_id      (src_id),
		.temperature (temperature),
		.id_limit    (id_limit_q),
		.cmd_full    (cmd_full),
		.clearing    (clearing),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	psma_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign cmd_out = cmd_t'(cmd_rdata);

	psma_back #(
		.NUM_SENSORS (NUM_SENSORS),
		.WINDOW      (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr       (thr),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full),
		.clearing  (clearing)
	);

	psma_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out = res_t'(res_rdata);
	assign node_id = res_out.node_id;
	assign average = res_out.average;
	assign level   = res_out.level;
	assign changed = res_out.changed;
	assign bad_id  = res_out.bad_id;

endmodule

/* tb/sv/per_sensor_moving_average_alarm_core_test.sv */
`timescale 1ns / 1ps
module per_sensor_moving_average_alarm_core_test;
	import psma_pkg::*;

	localparam int NUM_SENSORS = DEF_NUM_SENSORS;
	localparam int WINDOW      = DEF_WINDOW;
	localparam int POOL_SIZE   = 8;

	localparam int REG_HOT   = 0;
	localparam int REG_COLD  = 1;
	localparam int REG_LIMIT = 2;

	localparam logic [1:0] LVL_NORMAL = 2'd0;
	localparam logic [1:0] LVL_HOT    = 2'd1;
	localparam logic [1:0] LVL_COLD   = 2'd2;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [3:0]         paddr       = '0;
	logic [31:0]        pwdata      = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               push        = 1'b0;
	logic               full;
	logic [15:0]        src_id      = '0;
	logic signed [15:0] temperature = '0;
	logic               empty;
	logic               pop         = 1'b0;
	logic [15:0]        node_id;
	logic signed [15:0] average;
	logic [1:0]         level;
	logic               changed;
	logic               bad_id;

	per_sensor_moving_average_alarm_core DUT (.*);

	typedef struct {
		logic [15:0]        id;
		logic signed [15:0] temp;
		bit                 typed;
		logic signed [15:0] avg;
		logic [1:0]         lvl;
		bit                 chg;
		bit                 bad;
	} reading_row_t;

	reading_row_t directed_rows [23] = '{
		'{16'd0,    16'sd0,    1'b1, 16'sd0,    LVL_COLD,   1'b1, 1'b0},
		'{16'd999,  16'sh7FFF, 1'b1, 16'sh7FFF, LVL_HOT,    1'b1, 1'b0},
		'{16'd1000, 16'sd5000, 1'b1, 16'sd0,    LVL_NORMAL, 1'b0, 1'b1},
		'{16'hFFFF, 16'sh8000, 1'b1, 16'sd0,    LVL_NORMAL, 1'b0, 1'b1},
		'{16'd1023, 16'sd100,  1'b1, 16'sd0,    LVL_NORMAL, 1'b0, 1'b1},
		'{16'd1,    16'sh8000, 1'b1, 16'sh8000, LVL_COLD,   1'b1, 1'b0},
		'{16'd1,    16'sh8000, 1'b1, 16'sh8000, LVL_COLD,   1'b0, 1'b0},
		'{16'd2,    16'sd7168, 1'b1, 16'sd7168, LVL_NORMAL, 1'b0, 1'b0},
		'{16'd3,    16'sd7169, 1'b1, 16'sd7169, LVL_HOT,    1'b1, 1'b0},
		'{16'd4,    16'sd4608, 1'b1, 16'sd4608, LVL_NORMAL, 1'b0, 1'b0},
		'{16'd5,    16'sd4607, 1'b1, 16'sd4607, LVL_COLD,   1'b1, 1'b0},
		'{16'd3,    16'sd0,    1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd7,    16'sh7FFF, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd7,    16'sh7FFF, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd7,    16'sh8000, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd7,    16'sh7FFF, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd7,    16'sh8000, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd7,    16'sd100,  1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd7,    16'sh7FFF, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd8,    16'shFFFF, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd8,    16'shFFFE, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd8,    16'sd0,    1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0},
		'{16'd999,  16'sh8000, 1'b0, 16'sd0,    LVL_NORMAL, 1'b0, 1'b0}
	};

	logic signed [15:0] hot_thr  = 16'sd7168;
	logic signed [15:0] cold_thr = 16'sd4608;
	int                 id_lim   = 1000;

	logic signed [15:0] sample_mem [NUM_SENSORS][WINDOW];
	int                 ring_pos   [NUM_SENSORS];
	int                 fill_cnt   [NUM_SENSORS];
	logic [1:0]         prev_level [NUM_SENSORS];

	logic [15:0] id_pool [POOL_SIZE];
	res_t        alarm_queue [$];
	int          mismatch_count = 0;
	bit          steady = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("per_sensor_moving_average_alarm_core test failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < 40)
			$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	function automatic res_t classify_reading(input logic [15:0] id,
			input logic signed [15:0] temp);
		res_t       r;
		int         pos;
		int         cnt;
		int         total;
		int         mean;
		logic [1:0] lvl;
		r = '0;
		if (int'(id) >= id_lim || int'(id) >= NUM_SENSORS) begin
			r.bad_id = 1'b1;
			return r;
		end
		pos = ring_pos[id];
		sample_mem[id][pos] = temp;
		ring_pos[id] = (pos == WINDOW - 1) ? 0 : pos + 1;
		if (fill_cnt[id] < WINDOW)
			fill_cnt[id]++;
		cnt = fill_cnt[id];
		total = 0;
		for (int i = 0; i < cnt; i++)
			total += int'(sample_mem[id][i]);
		mean = total / cnt;
		if (mean > int'(hot_thr))
			lvl = LVL_HOT;
		else if (mean < int'(cold_thr))
			lvl = LVL_COLD;
		else
			lvl = LVL_NORMAL;
		r.node_id = id;
		r.average = mean[15:0];
		r.level   = lvl;
		r.changed = (lvl != prev_level[id]);
		prev_level[id] = lvl;
		return r;
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] pick_temperature();
		int r;
		int center;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			center = ($urandom_range(0, 1) == 1) ? int'(hot_thr) : int'(cold_thr);
			return clamp16(center + int'($urandom_range(0, 1200)) - 600);
		end
		if (r < 60)
			return 16'($urandom);
		if (r < 75) begin
			case ($urandom_range(0, 3))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh8001;
				default: return 16'sh7FFE;
			endcase
		end
		return clamp16(int'($urandom_range(0, 12000)) - 2000);
	endfunction

	function automatic logic [15:0] pick_sensor();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 65)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 80)
			return 16'($urandom_range(0, NUM_SENSORS - 1));
		if (r < 88) begin
			v = id_lim + int'($urandom_range(0, 3)) - 2;
			if (v < 0)
				v = 0;
			return 16'(v);
		end
		return 16'($urandom);
	endfunction

	task automatic fill_pool();
		int acc;
		acc = (id_lim < NUM_SENSORS) ? id_lim : NUM_SENSORS;
		if (acc == 0)
			acc = 1;
		id_pool[0] = '0;
		id_pool[1] = 16'(acc - 1);
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = 16'($urandom_range(0, acc - 1));
	endtask

	task automatic set_register(input int idx, input int value);
		logic [31:0] rd;
		logic [31:0] mask;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_HOT:   hot_thr  = value[15:0];
			REG_COLD:  cold_thr = value[15:0];
			REG_LIMIT: id_lim   = int'(value[10:0]);
			default: ;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		mask = (idx == REG_LIMIT) ? 32'h7FF : 32'hFFFF;
		if ((rd & mask) != (value & mask))
			report_mismatch("register readback", int'(rd & mask), int'(value & mask));
	endtask

	task automatic send_reading(input logic [15:0] id, input logic signed [15:0] temp,
			input bit typed, input res_t typed_res);
		res_t r;
		while (!steady && $urandom_range(0, 99) < 19) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		src_id      <= id;
		temperature <= temp;
		do @(posedge clk); while (full);
		r = classify_reading(id, temp);
		alarm_queue.push_back(typed ? typed_res : r);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (alarm_queue.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (alarm_queue.size() == 0) begin
				report_mismatch("result with no reading pending, node_id", int'(node_id), -1);
			end else begin
				want = alarm_queue.pop_front();
				if (node_id != want.node_id)
					report_mismatch("node_id", int'(node_id), int'(want.node_id));
				if (average != want.average)
					report_mismatch("average", int'(average), int'(want.average));
				if (level != want.level)
					report_mismatch("level", int'(level), int'(want.level));
				if (changed != want.changed)
					report_mismatch("changed", int'(changed), int'(want.changed));
				if (bad_id != want.bad_id)
					report_mismatch("bad_id", int'(bad_id), int'(want.bad_id));
			end
		end
		pop <= steady || ($urandom_range(0, 99) >= 19);
	end

	initial begin
		int   n_items;
		int   h;
		int   c;
		int   lim;
		res_t want;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			ring_pos[i]   = 0;
			fill_cnt[i]   = 0;
			prev_level[i] = LVL_NORMAL;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (full);

		for (int k = 0; k < $size(directed_rows); k++) begin
			want.node_id = directed_rows[k].bad ? 16'd0 : directed_rows[k].id;
			want.average = directed_rows[k].avg;
			want.level   = directed_rows[k].lvl;
			want.changed = directed_rows[k].chg;
			want.bad_id  = directed_rows[k].bad;
			send_reading(directed_rows[k].id, directed_rows[k].temp,
				directed_rows[k].typed, want);
		end
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			steady = 1'b0;
			case (ph)
				0: begin
					h = -32768; c = 32767; lim = 1024; n_items = 300;
				end
				1: begin
					h = 32767; c = -32768; lim = 0; n_items = 50;
				end
				2: begin
					h = 0; c = 0; lim = 1; n_items = 120;
				end
				3: begin
					c = int'($urandom_range(0, 12000)) - 2000;
					h = c + int'($urandom_range(0, 6000));
					lim = $urandom_range(1, 1024);
					n_items = 320;
					steady = 1'b1;
				end
				4: begin
					h = int'($urandom_range(0, 65535)) - 32768;
					c = int'($urandom_range(0, 65535)) - 32768;
					lim = $urandom_range(512, 1024);
					n_items = 320;
				end
				default: begin
					h = 7168; c = 4608; lim = 1000; n_items = 140;
				end
			endcase
			set_register(REG_HOT, h);
			set_register(REG_COLD, c);
			set_register(REG_LIMIT, lim);
			fill_pool();
			for (int k = 0; k < n_items; k++) begin
				if (k == n_items / 2 && (ph == 0 || ph == 4))
					wait_drained();
				send_reading(pick_sensor(), pick_temperature(), 1'b0, '0);
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (alarm_queue.size() != 0)
			report_mismatch("results never delivered", alarm_queue.size(), 0);
		if (mismatch_count == 0)
			$display("per_sensor_moving_average_alarm_core test passed");
		else
			$display("per_sensor_moving_average_alarm_core test failed");
		$finish;
	end

endmodule
